[hw/rtl/iptq_pkg.sv]
`default_nettype none
package iptq_pkg;

    localparam int DATA_W  = 32;
    localparam int MAG_W   = 31;
    localparam int SHIFT_W = 5;
    localparam int VBITS_W = 5;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [VBITS_W-1:0] VBITS_RESET = VBITS_W'(8);
    localparam logic [VBITS_W-1:0] VBITS_MIN   = VBITS_W'(2);

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_MEASURE = 2'd1,
        ACT_CONVERT = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_IN_RANGE = 2'd0,
        STAT_ABOVE    = 2'd1,
        STAT_BELOW    = 2'd2
    } t_status;

endpackage
`default_nettype wire

[hw/rtl/iptq_absmax.sv]
`default_nettype none
module iptq_absmax
    import iptq_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_upd,
    input  t_action                  i_action,
    input  wire signed [DATA_W-1:0]  i_sample,
    output logic [SHIFT_W-1:0]       o_len
);

    logic [MAG_W-1:0]  r_max;
    logic [MAG_W-1:0]  n_max;
    logic [DATA_W-1:0] mag;
    logic [MAG_W-1:0]  mag_sat;

    always_comb begin
        mag     = i_sample[DATA_W-1] ? (DATA_W'(0) - i_sample) : i_sample;
        // the most negative sample saturates to the largest magnitude
        mag_sat = mag[DATA_W-1] ? {MAG_W{1'b1}} : mag[MAG_W-1:0];
        n_max   = r_max;
        if (i_upd) begin
            case (i_action)
                ACT_CLEAR:   n_max = '0;
                ACT_MEASURE: if (mag_sat > r_max) n_max = mag_sat;
                default:     n_max = r_max;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else begin
            r_max <= n_max;
        end
    end

    // bit length of the maximum, one when it is zero
    always_comb begin
        o_len = SHIFT_W'(1);
        for (int i = 0; i < MAG_W; i++) begin
            if (r_max[i]) o_len = SHIFT_W'(i + 1);
        end
    end

endmodule
`default_nettype wire

[hw/rtl/iptq_convert.sv]
`default_nettype none
module iptq_convert
    import iptq_pkg::*;
(
    input  wire        [VBITS_W-1:0] i_value_bits,
    input  wire        [SHIFT_W-1:0] i_len,
    input  wire signed [DATA_W-1:0]  i_sample,
    output logic signed [DATA_W-1:0] o_quantized,
    output t_status                  o_status,
    output logic       [SHIFT_W-1:0] o_shift
);

    logic        [VBITS_W-1:0] b_eff;
    logic        [VBITS_W-1:0] offset;
    logic signed [DATA_W-1:0]  high_part;

    always_comb begin
        b_eff       = (i_value_bits < VBITS_MIN) ? VBITS_MIN : i_value_bits;
        offset      = b_eff - VBITS_W'(1);
        o_shift     = (i_len > offset) ? (i_len - offset) : '0;
        o_quantized = i_sample >>> o_shift;
        // in range when everything above the sign position is pure sign extension
        high_part   = o_quantized >>> offset;
        if (!o_quantized[DATA_W-1] && (high_part != '0)) begin
            o_status = STAT_ABOVE;
        end else if (o_quantized[DATA_W-1] && (high_part != '1)) begin
            o_status = STAT_BELOW;
        end else begin
            o_status = STAT_IN_RANGE;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/int_power_of_two_quantizer.sv]
`default_nettype none
// A convert word passes from the input register to the output register.
// Throughput: one word per cycle while the output is not stalled; the maximum
// update, bit-length encode and barrel shift all sit between the two registers.
// Clear and measure words produce no output word.
// Reset (synchronous, active low) empties both stages, clears the running
// maximum and sets value_bits to 8.
module int_power_of_two_quantizer
    import iptq_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_wr_en,
    input  wire        [VBITS_W-1:0] i_cfg_wr_data,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire        [ACT_W-1:0]   i_action,
    input  wire signed [DATA_W-1:0]  i_sample,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output logic signed [DATA_W-1:0] o_quantized,
    output logic       [STAT_W-1:0]  o_status,
    output logic       [SHIFT_W-1:0] o_shift_used
);

    logic [VBITS_W-1:0] r_value_bits;

    logic                     r_s1_valid;
    t_action                  r_s1_action;
    logic signed [DATA_W-1:0] r_s1_sample;

    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_quantized;
    t_status                   r_status;
    logic        [SHIFT_W-1:0] r_shift_used;

    logic                     out_free;
    logic                     s1_is_conv;
    logic                     s1_go;
    logic                     in_take;
    logic [SHIFT_W-1:0]       len;
    logic signed [DATA_W-1:0] c_quantized;
    t_status                  c_status;
    logic [SHIFT_W-1:0]       c_shift;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_is_conv = (r_s1_action == ACT_CONVERT);
    // a word that makes no output leaves stage one regardless of the output side
    assign s1_go      = r_s1_valid && (out_free || !s1_is_conv);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_take    = i_in_valid && !o_in_stall;

    iptq_absmax u_absmax (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (s1_go),
        .i_action (r_s1_action),
        .i_sample (r_s1_sample),
        .o_len    (len)
    );

    iptq_convert u_convert (
        .i_value_bits (r_value_bits),
        .i_len        (len),
        .i_sample     (r_s1_sample),
        .o_quantized  (c_quantized),
        .o_status     (c_status),
        .o_shift      (c_shift)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_bits <= VBITS_RESET;
        end else if (i_cfg_wr_en) begin
            r_value_bits <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_action <= t_action'(i_action);
            r_s1_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_is_conv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // load the result word; hold it while stalled
    always_ff @(posedge i_clk) begin
        if (s1_go && s1_is_conv) begin
            r_quantized  <= c_quantized;
            r_status     <= c_status;
            r_shift_used <= c_shift;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_quantized  = r_quantized;
    assign o_status     = r_status;
    assign o_shift_used = r_shift_used;

endmodule
`default_nettype wire

[bench/int_power_of_two_quantizer_tb.sv]
module int_power_of_two_quantizer_tb;
    import iptq_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int WORD_TARGET = 1250;
    localparam int HOLD_CYCLES = 4;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic signed [DATA_W-1:0] quantized;
        t_status                  status;
        logic [SHIFT_W-1:0]       shift_used;
    } t_quant_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic        [VBITS_W-1:0] i_cfg_wr_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic        [ACT_W-1:0]   i_action = ACT_CLEAR;
    logic signed [DATA_W-1:0]  i_sample = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [DATA_W-1:0]  o_quantized;
    logic        [STAT_W-1:0]  o_status;
    logic        [SHIFT_W-1:0] o_shift_used;

    // predictor state
    logic [MAG_W-1:0]   abs_peak = '0;
    logic [VBITS_W-1:0] width_cfg = VBITS_RESET;
    t_quant_word        due_quant[$];

    logic signed [DATA_W-1:0] seen_samples[$];
    int  err_count = 0;
    int  word_count = 0;
    int  out_wait = 0;
    int  quiet_cycles = 0;
    bit  send_pacing = 1'b1;
    bit  recv_pacing = 1'b1;

    int_power_of_two_quantizer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_quantized   (o_quantized),
        .o_status      (o_status),
        .o_shift_used  (o_shift_used)
    );

    always #2 i_clk = ~i_clk;

    task automatic quantize_word(input logic [ACT_W-1:0] act,
                                 input logic signed [DATA_W-1:0] smp);
        logic [DATA_W-1:0] mag;
        int          b;
        int          len;
        int          sh;
        longint      bound;
        longint      qv;
        t_quant_word w;
        case (act)
            ACT_CLEAR: begin
                abs_peak = '0;
            end
            ACT_MEASURE: begin
                mag = smp[DATA_W-1] ? (32'd0 - smp) : smp;
                // the most negative sample saturates
                if (mag > 32'h7FFF_FFFF)
                    mag = 32'h7FFF_FFFF;
                if (mag[MAG_W-1:0] > abs_peak)
                    abs_peak = mag[MAG_W-1:0];
            end
            ACT_CONVERT: begin
                b = (width_cfg < VBITS_MIN) ? int'(VBITS_MIN) : int'(width_cfg);
                len = 0;
                for (int i = 0; i < MAG_W; i++)
                    if (abs_peak[i])
                        len = i + 1;
                if (len == 0)
                    len = 1;
                sh = (len > b - 1) ? len - (b - 1) : 0;
                w.quantized = smp >>> sh;
                w.shift_used = SHIFT_W'(sh);
                qv = w.quantized;
                bound = (longint'(1) << (b - 1)) - 1;
                if (qv > bound)
                    w.status = STAT_ABOVE;
                else if (qv < -(bound + 1))
                    w.status = STAT_BELOW;
                else
                    w.status = STAT_IN_RANGE;
                due_quant.push_back(w);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s at %0t: got %h want %h", what, $realtime, got, want);
        err_count++;
    endtask

    // drive one word and hold it until accepted
    task automatic send_word(input logic [ACT_W-1:0] act,
                             input logic signed [DATA_W-1:0] smp);
        int gap;
        gap = send_pacing ? $urandom_range(0, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_sample <= smp;
        do @(posedge i_clk); while (o_in_stall);
        quantize_word(act, smp);
        if (act == ACT_MEASURE) begin
            seen_samples.push_back(smp);
            if (seen_samples.size() > 16)
                void'(seen_samples.pop_front());
        end
        if (act != ACT_UNUSED)
            word_count++;
    endtask

    // drop valid, wait out every expected word, then let in-flight words retire
    task automatic settle_pipeline();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_quant.size() != 0)
            @(posedge i_clk);
        repeat (HOLD_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_width(input logic [VBITS_W-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        width_cfg = v;
    endtask

    function automatic logic signed [DATA_W-1:0] rand_sample();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    v = 32'd0 - v;
            end
            2: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h0000_0000;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'h0000_0001;
                    3: v = 32'h7FFF_FFFF;
                    4: v = 32'h8000_0000;
                    default: v = 32'h8000_0001;
                endcase
            end
            default: v = 32'($urandom_range(0, 1023)) - 32'd512;
        endcase
        return v;
    endfunction

    function automatic logic signed [DATA_W-1:0] convert_sample();
        if (seen_samples.size() != 0 && $urandom_range(0, 1))
            return seen_samples[$urandom_range(0, seen_samples.size() - 1)];
        return rand_sample();
    endfunction

    // clear, measure pass, convert pass; now and then a broken or noisy one
    task automatic run_frame();
        int n_meas;
        int n_conv;
        if ($urandom_range(0, 3) != 0) begin
            send_word(ACT_CLEAR, rand_sample());
            seen_samples.delete();
        end
        n_meas = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
        n_conv = $urandom_range(1, 8);
        repeat (n_meas) send_word(ACT_MEASURE, rand_sample());
        repeat (n_conv) begin
            if ($urandom_range(0, 15) == 0)
                send_word(ACT_UNUSED, rand_sample());
            if ($urandom_range(0, 15) == 0)
                send_word(ACT_MEASURE, rand_sample());
            send_word(ACT_CONVERT, convert_sample());
        end
    endtask

    task automatic test_reset_and_edges();
        // reset width of 8 applies before any write
        send_word(ACT_CONVERT, 32'sd0);
        send_word(ACT_CONVERT, 32'sd127);
        send_word(ACT_CONVERT, 32'sd128);
        send_word(ACT_CONVERT, -32'sd128);
        send_word(ACT_CONVERT, -32'sd129);
        send_word(ACT_CONVERT, 32'h7FFF_FFFF);
        send_word(ACT_CONVERT, 32'h8000_0000);
        send_word(ACT_MEASURE, 32'h8000_0000);
        send_word(ACT_CONVERT, 32'h7FFF_FFFF);
        send_word(ACT_CONVERT, 32'h8000_0000);
        send_word(ACT_UNUSED, 32'sd5);
        send_word(ACT_CONVERT, -32'sd1);
        send_word(ACT_CLEAR, 32'h7FFF_FFFF);
        send_word(ACT_MEASURE, 32'sd1);
        send_word(ACT_CONVERT, 32'sd200);
        send_word(ACT_MEASURE, -32'sd300);
        send_word(ACT_CONVERT, 32'sd300);
        send_word(ACT_CONVERT, -32'sd513);
        send_word(ACT_MEASURE, 32'h7FFF_FFFF);
        send_word(ACT_CONVERT, 32'h7FFF_FFFF);
        send_word(ACT_CLEAR, 32'sd0);
        send_word(ACT_UNUSED, 32'h8000_0000);
        send_word(ACT_CONVERT, 32'h0000_00FF);
    endtask

    task automatic test_width_sweep();
        logic [VBITS_W-1:0] widths[7] = '{5'd0, 5'd1, 5'd2, 5'd31, 5'd30, 5'd16, 5'd5};
        foreach (widths[i]) begin
            settle_pipeline();
            write_width(widths[i]);
            send_word(ACT_MEASURE, 32'h8000_0000);
            send_word(ACT_CONVERT, 32'h7FFF_FFFF);
            send_word(ACT_CONVERT, 32'h8000_0000);
            repeat (3) run_frame();
        end
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            run_frame();
            settle_pipeline();
        end
    endtask

    task automatic test_random_frames();
        while (word_count < WORD_TARGET) begin
            send_pacing = ($urandom_range(0, 5) != 0);
            recv_pacing = ($urandom_range(0, 5) != 0);
            run_frame();
            if ($urandom_range(0, 11) == 0) begin
                settle_pipeline();
                write_width(VBITS_W'($urandom_range(0, 31)));
            end else if ($urandom_range(0, 9) == 0) begin
                settle_pipeline();
            end
        end
        send_pacing = 1'b1;
        recv_pacing = 1'b1;
    endtask

    // receiver: hold stall for a drawn number of cycles after each word
    always @(negedge i_clk) begin
        if (out_wait > 0) begin
            i_out_stall <= 1'b1;
            out_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_quant_word w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_quant.size() == 0) begin
                report_mismatch("unexpected word", o_quantized, 32'h0);
            end else begin
                w = due_quant.pop_front();
                if (o_quantized !== w.quantized)
                    report_mismatch("quantized", o_quantized, w.quantized);
                if (o_status !== w.status)
                    report_mismatch("status", 32'(o_status), 32'(w.status));
                if (o_shift_used !== w.shift_used)
                    report_mismatch("shift_used", 32'(o_shift_used), 32'(w.shift_used));
            end
            out_wait = recv_pacing ? $urandom_range(0, 5) : 0;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_and_edges();
        test_width_sweep();
        test_drain_pause();
        test_random_frames();
        settle_pipeline();
        repeat (10) @(posedge i_clk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/iptq_pkg.sv
hw/rtl/iptq_absmax.sv
hw/rtl/iptq_convert.sv
hw/rtl/int_power_of_two_quantizer.sv
bench/int_power_of_two_quantizer_tb.sv
